// ----- rtl/prg_pkg.sv -----
// shared types and constants for the pinhole ray generator
package prg_pkg;

  localparam int PIX_BITS   = 12;
  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int CFG_W      = 64;
  localparam int ADDR_W     = 6;
  localparam int RAW_W      = 62;   // raw direction magnitude
  localparam int NORM_W     = 30;   // normalized magnitude, top bit at NORM_W-1
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W + 1;
  localparam int LEN_W      = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W / 2 + 1;
  localparam int DIV_STEPS  = NORM_W + 1;
  localparam int REM_W      = LEN_W + 1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    REG_ROW0_L  = 3'd0,
    REG_ROW0_R  = 3'd1,
    REG_ROW1_L  = 3'd2,
    REG_ROW1_R  = 3'd3,
    REG_ROW2_L  = 3'd4,
    REG_ROW2_R  = 3'd5,
    REG_PIX_HW  = 3'd6,
    REG_HALF_H  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    word_t [2:0][2:0] m;   // m[row][col], linear part of the inverse matrix
    word_t            psize;
    word_t            half_w;
    word_t            half_h;
  } cfg_t;

  // what travels next to the length and quotient pipelines
  typedef struct packed {
    logic [2:0][NORM_W-1:0] nm;
    logic [2:0]             neg;
    logic                   zero;
  } dir_side_t;

endpackage

// ----- rtl/prg_front.sv -----
// canvas point and matrix transform stages
module prg_front import prg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  input  logic [PIX_BITS-1:0]      col,
  input  logic [PIX_BITS-1:0]      row,
  output logic                     out_valid,
  output logic [2:0][RAW_W-1:0]    mag,
  output logic [2:0]               neg
);

  localparam int PW = WORD_W + PIX_BITS + 2;

  function automatic word_t canvas(word_t half, logic signed [PW-1:0] p);
    logic signed [PW:0]   w2;
    logic signed [PW-1:0] h;
    begin
      w2 = $signed({{(PW-WORD_W-1){half[WORD_W-1]}}, half, 1'b0}) - $signed({p[PW-1], p});
      w2 = w2 + (PW+1)'(1);
      h  = w2[PW:1];
      if ((&h[PW-1:WORD_W-1]) || !(|h[PW-1:WORD_W-1]))
        canvas = h[WORD_W-1:0];
      else if (h[PW-1])
        canvas = {1'b1, {(WORD_W-1){1'b0}}};
      else
        canvas = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  logic signed [PW-1:0] pc, pr;
  logic signed [PW-1:0] pc_r, pr_r;
  logic                 va_r, vb_r, vc_r, vd_r, ve_r;
  word_t                x_r, y_r;
  logic signed [63:0]   prod_r [3][2];
  logic signed [63:0]   d_r [3];
  logic [2:0][RAW_W-1:0] mag_r;
  logic [2:0]           neg_r;

  assign pc = $signed(cfg.psize) * $signed({1'b0, col, 1'b1});
  assign pr = $signed(cfg.psize) * $signed({1'b0, row, 1'b1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc_r <= pc;
      pr_r <= pr;
      x_r  <= canvas(cfg.half_w, pc_r);
      y_r  <= canvas(cfg.half_h, pr_r);
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= $signed(cfg.m[i][0]) * $signed(x_r);
        prod_r[i][1] <= $signed(cfg.m[i][1]) * $signed(y_r);
        // z of the canvas point is -1
        d_r[i] <= (prod_r[i][0] >>> 2) + (prod_r[i][1] >>> 2)
                - ($signed({{WORD_W{cfg.m[i][2][WORD_W-1]}}, cfg.m[i][2]}) <<< (FRAC_BITS-2));
        neg_r[i] <= d_r[i][63];
        mag_r[i] <= d_r[i][63] ? RAW_W'(-d_r[i]) : RAW_W'(d_r[i]);
      end
    end
  end

  assign out_valid = ve_r;
  assign mag       = mag_r;
  assign neg       = neg_r;

endmodule

// ----- rtl/prg_norm.sv -----
// common-shift normalization and sum of squares
module prg_norm import prg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [2:0][RAW_W-1:0] mag,
  input  logic [2:0]            neg,
  output logic                  out_valid,
  output logic [SUM_W-1:0]      sum,
  output dir_side_t             side
);

  localparam int PAD_W = 64;

  logic [RAW_W-1:0]      orv;
  logic [PAD_W-1:0]      pad;
  logic [2:0]            grp;
  logic [2:0]            fine;
  logic [5:0]            pos;
  logic [2:0][NORM_W-1:0] nm;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [2:0]            grp_r;
  logic [7:0]            byte_r;
  logic                  zero1_r;
  logic [2:0][RAW_W-1:0] mag1_r;
  logic [2:0]            neg1_r;
  dir_side_t             s2_r, s3_r, s4_r;
  logic [SQ_W-1:0]       sq_r [3];
  logic [SUM_W-1:0]      sum_r;

  assign orv = mag[0] | mag[1] | mag[2];
  assign pad = {{(PAD_W-RAW_W){1'b0}}, orv};

  // highest nonzero byte of the or of all magnitudes
  always_comb begin
    grp = '0;
    for (int g = 0; g < 8; g++)
      if (|pad[g*8 +: 8]) grp = 3'(g);
  end

  always_comb begin
    fine = '0;
    for (int b = 0; b < 8; b++)
      if (byte_r[b]) fine = 3'(b);
  end

  assign pos = {grp_r, fine};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos >= 6'(NORM_W-1))
        nm[i] = NORM_W'(mag1_r[i] >> (pos - 6'(NORM_W-1)));
      else
        nm[i] = NORM_W'(mag1_r[i] << (6'(NORM_W-1) - pos));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r   <= grp;
      byte_r  <= pad[{grp, 3'b000} +: 8];
      zero1_r <= ~|orv;
      mag1_r  <= mag;
      neg1_r  <= neg;
      s2_r.nm   <= nm;
      s2_r.neg  <= neg1_r;
      s2_r.zero <= zero1_r;
      for (int i = 0; i < 3; i++)
        sq_r[i] <= SQ_W'(s2_r.nm[i]) * SQ_W'(s2_r.nm[i]);
      s3_r  <= s2_r;
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      s4_r  <= s3_r;
    end
  end

  assign out_valid = v4_r;
  assign sum       = sum_r;
  assign side      = s4_r;

endmodule

// ----- rtl/prg_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module prg_sqrt import prg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] sum,
  input  dir_side_t        in_side,
  output logic             out_valid,
  output logic [LEN_W-1:0] len,
  output dir_side_t        out_side
);

  logic [ROOT_W-1:0] rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] res_r  [SQRT_STEPS];
  dir_side_t         side_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] v_r;

  logic [ROOT_W-1:0] rem_nxt [SQRT_STEPS];
  logic [ROOT_W-1:0] res_nxt [SQRT_STEPS];

  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      logic [ROOT_W-1:0] rem_c;
      logic [ROOT_W-1:0] res_c;
      logic [ROOT_W-1:0] bitv;
      logic [ROOT_W-1:0] trial;
      rem_c = (j == 0) ? ROOT_W'(sum) : rem_r[(j == 0) ? 0 : j-1];
      res_c = (j == 0) ? '0 : res_r[(j == 0) ? 0 : j-1];
      bitv  = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      trial = res_c + bitv;
      if (rem_c >= trial) begin
        rem_nxt[j] = rem_c - trial;
        res_nxt[j] = (res_c >> 1) + bitv;
      end else begin
        rem_nxt[j] = rem_c;
        res_nxt[j] = res_c >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        res_r[j]  <= res_nxt[j];
        side_r[j] <= (j == 0) ? in_side : side_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS-1];
  assign len       = res_r[SQRT_STEPS-1][LEN_W-1:0];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

// ----- rtl/prg_div.sv -----
// three-lane restoring divider, magnitude * 2^30 / length
module prg_div import prg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [LEN_W-1:0]       len,
  input  dir_side_t              in_side,
  output logic                   out_valid,
  output logic [2:0][NORM_W:0]   quo,
  output logic [2:0]             neg,
  output logic                   zero
);

  logic [2:0][REM_W-1:0] rem_r [DIV_STEPS];
  logic [2:0][NORM_W:0]  q_r   [DIV_STEPS];
  logic [LEN_W-1:0]      len_r [DIV_STEPS];
  logic [2:0]            neg_r [DIV_STEPS];
  logic                  zero_r [DIV_STEPS];
  logic [DIV_STEPS-1:0]  v_r;

  logic [2:0][REM_W-1:0] rem_nxt [DIV_STEPS];
  logic [2:0][NORM_W:0]  q_nxt   [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        logic [REM_W-1:0] rem_c;
        logic [NORM_W:0]  q_c;
        logic [LEN_W-1:0] d_c;
        logic [REM_W-1:0] t;
        // the dividend is nm << 30: its top part starts below the divisor
        rem_c = (j == 0) ? REM_W'(in_side.nm[i] >> 1) : rem_r[(j == 0) ? 0 : j-1][i];
        q_c   = (j == 0) ? '0 : q_r[(j == 0) ? 0 : j-1][i];
        d_c   = (j == 0) ? len : len_r[(j == 0) ? 0 : j-1];
        t     = {rem_c[REM_W-2:0], (j == 0) ? in_side.nm[i][0] : 1'b0};
        if (t >= REM_W'(d_c)) begin
          rem_nxt[j][i] = t - REM_W'(d_c);
          q_nxt[j][i]   = {q_c[NORM_W-1:0], 1'b1};
        end else begin
          rem_nxt[j][i] = t;
          q_nxt[j][i]   = {q_c[NORM_W-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        len_r[j]  <= (j == 0) ? len : len_r[(j == 0) ? 0 : j-1];
        neg_r[j]  <= (j == 0) ? in_side.neg : neg_r[(j == 0) ? 0 : j-1];
        zero_r[j] <= (j == 0) ? in_side.zero : zero_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign quo       = q_r[DIV_STEPS-1];
  assign neg       = neg_r[DIV_STEPS-1];
  assign zero      = zero_r[DIV_STEPS-1];

endmodule

// ----- rtl/pinhole_ray_generator_top.sv -----
// each accepted pixel yields its ray on the output register
// throughput: one ray per cycle, the whole pipeline advances together when the
// output register is empty or being taken; the square root (32 stages) and the
// divider (31 stages) set the depth
// reset: synchronous active-low rst_n clears all valid bits and loads the identity matrix
module pinhole_ray_generator_top import prg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIX_BITS-1:0] in_pixel_col,
  input  logic [PIX_BITS-1:0] in_pixel_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_origin_x,
  output logic [WORD_W-1:0]   out_origin_y,
  output logic [WORD_W-1:0]   out_origin_z,
  output logic [WORD_W-1:0]   out_dir_x,
  output logic [WORD_W-1:0]   out_dir_y,
  output logic [WORD_W-1:0]   out_dir_z,
  output logic                out_degenerate,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]    prdata,
  output logic                pready
);

  logic [CFG_W-1:0] regs_r [8];
  reg_idx_t         idx;
  cfg_t             cfg;
  logic             adv;

  logic                  f_valid;
  logic [2:0][RAW_W-1:0] f_mag;
  logic [2:0]            f_neg;
  logic                  n_valid;
  logic [SUM_W-1:0]      n_sum;
  dir_side_t             n_side;
  logic                  s_valid;
  logic [LEN_W-1:0]      s_len;
  dir_side_t             s_side;
  logic                  d_valid;
  logic [2:0][NORM_W:0]  d_quo;
  logic [2:0]            d_neg;
  logic                  d_zero;

  logic                  out_valid_r;
  logic [2:0][WORD_W-1:0] dir_r;
  logic                  degen_r;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_ROW0_L] <= CFG_W'(1) << (WORD_W + FRAC_BITS);
      regs_r[REG_ROW0_R] <= '0;
      regs_r[REG_ROW1_L] <= CFG_W'(1) << FRAC_BITS;
      regs_r[REG_ROW1_R] <= '0;
      regs_r[REG_ROW2_L] <= '0;
      regs_r[REG_ROW2_R] <= CFG_W'(1) << (WORD_W + FRAC_BITS);
      regs_r[REG_PIX_HW] <= '0;
      regs_r[REG_HALF_H] <= '0;
    end else if (psel && penable && pwrite) begin
      if (idx == REG_HALF_H)
        regs_r[idx] <= {{WORD_W{1'b0}}, pwdata[WORD_W-1:0]};
      else
        regs_r[idx] <= pwdata;
    end
  end

  assign prdata = regs_r[idx];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.m[i][0] = regs_r[2*i][CFG_W-1:WORD_W];
      cfg.m[i][1] = regs_r[2*i][WORD_W-1:0];
      cfg.m[i][2] = regs_r[2*i+1][CFG_W-1:WORD_W];
    end
    cfg.psize  = regs_r[REG_PIX_HW][CFG_W-1:WORD_W];
    cfg.half_w = regs_r[REG_PIX_HW][WORD_W-1:0];
    cfg.half_h = regs_r[REG_HALF_H][WORD_W-1:0];
  end

  // every stage moves when the output register can take a transaction
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  prg_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .cfg(cfg),
    .in_valid(in_valid), .col(in_pixel_col), .row(in_pixel_row),
    .out_valid(f_valid), .mag(f_mag), .neg(f_neg)
  );

  prg_norm u_norm (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(f_valid), .mag(f_mag), .neg(f_neg),
    .out_valid(n_valid), .sum(n_sum), .side(n_side)
  );

  prg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(n_valid), .sum(n_sum), .in_side(n_side),
    .out_valid(s_valid), .len(s_len), .out_side(s_side)
  );

  prg_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(s_valid), .len(s_len), .in_side(s_side),
    .out_valid(d_valid), .quo(d_quo), .neg(d_neg), .zero(d_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_r <= d_zero;
      for (int i = 0; i < 3; i++) begin
        if (d_zero)
          dir_r[i] <= '0;
        else if (d_neg[i])
          dir_r[i] <= -WORD_W'(d_quo[i]);
        else
          dir_r[i] <= WORD_W'(d_quo[i]);
      end
    end
  end

  // origins are the translation column; the user must keep them constant while items are in flight, not enforced here
  assign out_origin_x   = regs_r[REG_ROW0_R][WORD_W-1:0];
  assign out_origin_y   = regs_r[REG_ROW1_R][WORD_W-1:0];
  assign out_origin_z   = regs_r[REG_ROW2_R][WORD_W-1:0];
  assign out_valid      = out_valid_r;
  assign out_dir_x      = dir_r[0];
  assign out_dir_y      = dir_r[1];
  assign out_dir_z      = dir_r[2];
  assign out_degenerate = degen_r;

endmodule

// ----- rtl/prg_checker.sv -----
// port-level checker for the ray generator, bound to the top level
module prg_checker import prg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [WORD_W-1:0]   out_dir_x,
  input logic [WORD_W-1:0]   out_dir_y,
  input logic [WORD_W-1:0]   out_dir_z,
  input logic                out_degenerate
);

  localparam logic signed [WORD_W-1:0] ONE_Q30  = WORD_W'(1) << 30;
  localparam logic signed [WORD_W-1:0] MONE_Q30 = -(WORD_W'(1) << 30);

  // a held transaction keeps its direction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dir_x) && $stable(out_dir_y)
      && $stable(out_dir_z) && $stable(out_degenerate))
    else $error("stalled result changed");

  // input is held back only while a finished result waits
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_dir_x == '0 && out_dir_y == '0 && out_dir_z == '0)
    else $error("degenerate ray with nonzero direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_dir_x) <= ONE_Q30 && $signed(out_dir_x) >= MONE_Q30
      && $signed(out_dir_y) <= ONE_Q30 && $signed(out_dir_y) >= MONE_Q30
      && $signed(out_dir_z) <= ONE_Q30 && $signed(out_dir_z) >= MONE_Q30)
    else $error("direction component out of unit range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pinhole_ray_generator_top prg_checker u_prg_checker (.*);
